[rtl/ssot_pkg.sv]
// Shared widths and types for the swept sphere overlap test.
`default_nettype none
package ssot_pkg;

    localparam int CW  = 32;          // coordinate width
    localparam int RW  = 31;          // radius width
    localparam int DW  = CW + 1;      // coordinate difference magnitude
    localparam int LW  = 2 * DW;      // sum of three squared differences
    localparam int QLW = 2 * LW;      // product of two such sums
    localparam int RLW = RW + LW + 2; // interpolated radius times length
    localparam int FW  = QLW + LW;    // final compare width

    typedef struct packed {
        logic still;    // zero-length sweep
        logic near;     // start sphere overlap result for a zero-length sweep
        logic outside;  // projection falls outside the segment
    } side_t;

endpackage
`default_nettype wire

[rtl/ssot_mul.sv]
// Two-stage unsigned multiplier built from 32x32 partial products.
`default_nettype none
module ssot_mul
    #(
    parameter int AW = 32,
    parameter int BW = 32
    )
    (
    input  wire logic               clk,
    input  wire logic               en,
    input  wire logic [AW-1:0]      a,
    input  wire logic [BW-1:0]      b,
    output logic      [AW+BW-1:0]   p
    );

    localparam int NA = (AW + 31) / 32;
    localparam int NB = (BW + 31) / 32;
    localparam int PW = 32 * (NA + NB);

    logic [32*NA-1:0] ax;
    logic [32*NB-1:0] bx;
    logic [63:0]      pp_reg [NA*NB];
    logic [PW-1:0]    acc;
    logic [AW+BW-1:0] p_reg;

    assign ax = (32*NA)'(a);
    assign bx = (32*NB)'(b);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < NA; i++)
            begin
                for (int j = 0; j < NB; j++)
                begin
                    pp_reg[i*NB+j] <= 64'(ax[32*i +: 32]) * 64'(bx[32*j +: 32]);
                end
            end
        end
    end

    always_comb
    begin
        acc = '0;
        for (int i = 0; i < NA; i++)
        begin
            for (int j = 0; j < NB; j++)
            begin
                acc = acc + (PW'(pp_reg[i*NB+j]) << (32 * (i + j)));
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg <= acc[AW+BW-1:0];
        end
    end

    assign p = p_reg;

endmodule
`default_nettype wire

[rtl/swept_sphere_overlap_test.sv]
// Top level of the swept sphere overlap test pipeline.
//
// One transaction on the input channel carries a start sphere, an end sphere
// and a query sphere in signed fixed point. Each one yields exactly one output
// transaction; hit is set when the query overlaps the sweep at the projection
// of its centre, clear if that is off the segment; zero length: start sphere.
// out_valid and hit come from the last of the ten register stages, three pairs
// of which are the split wide multipliers. A new item can be accepted every
// cycle while the receiver is not stalling; throughput is one item per cycle
// under the same condition.
// All arithmetic is exact; products of up to 198 bits are formed from 32x32
// partial products registered before they are summed.
// Reset clears the valid bits of every stage; data registers hold no reset.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and in_ready drops; nothing is lost or repeated.
`default_nettype none
module swept_sphere_overlap_test
    import ssot_pkg::*;
    (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic signed [CW-1:0]  start_x,
    input  wire logic signed [CW-1:0]  start_y,
    input  wire logic signed [CW-1:0]  start_z,
    input  wire logic        [RW-1:0]  start_radius,
    input  wire logic signed [CW-1:0]  end_x,
    input  wire logic signed [CW-1:0]  end_y,
    input  wire logic signed [CW-1:0]  end_z,
    input  wire logic        [RW-1:0]  end_radius,
    input  wire logic signed [CW-1:0]  query_x,
    input  wire logic signed [CW-1:0]  query_y,
    input  wire logic signed [CW-1:0]  query_z,
    input  wire logic        [RW-1:0]  query_radius,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic                       hit
    );

    localparam int NST = 10;

    logic en;
    logic [NST-1:0] v_reg;

    assign en       = !v_reg[NST-1] || out_ready;
    assign in_ready = en;
    assign out_valid = v_reg[NST-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[NST-2:0], in_valid};
        end
    end

    // Stage 1: coordinate differences.
    logic signed [CW-1:0] sc [3];
    logic signed [CW-1:0] ec [3];
    logic signed [CW-1:0] qc [3];
    logic signed [DW-1:0] dp [3];
    logic signed [DW-1:0] pq [3];
    logic [DW-1:0] md_reg [3];
    logic [DW-1:0] mq_reg [3];
    logic [2:0]    sgn_reg [3];
    logic [2:0]    still_reg;
    logic [RW:0]   rsum_reg;
    logic [RW-1:0] r0_reg [3];
    logic [RW-1:0] r1_reg [3];
    logic [RW-1:0] rq_reg [3];

    assign sc = '{start_x, start_y, start_z};
    assign ec = '{end_x, end_y, end_z};
    assign qc = '{query_x, query_y, query_z};

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            dp[i] = DW'(ec[i]) - DW'(sc[i]);
            pq[i] = DW'(qc[i]) - DW'(sc[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                md_reg[i]     <= dp[i][DW-1] ? DW'(-dp[i]) : DW'(dp[i]);
                mq_reg[i]     <= pq[i][DW-1] ? DW'(-pq[i]) : DW'(pq[i]);
                sgn_reg[0][i] <= dp[i][DW-1] != pq[i][DW-1];
            end
            still_reg[0] <= (dp[0] == '0) && (dp[1] == '0) && (dp[2] == '0);
            rsum_reg     <= (RW+1)'(start_radius) + (RW+1)'(query_radius);
            r0_reg[0]    <= start_radius;
            r1_reg[0]    <= end_radius;
            rq_reg[0]    <= query_radius;
            for (int k = 1; k < 3; k++)
            begin
                sgn_reg[k]   <= sgn_reg[k-1];
                still_reg[k] <= still_reg[k-1];
                r0_reg[k]    <= r0_reg[k-1];
                r1_reg[k]    <= r1_reg[k-1];
                rq_reg[k]    <= rq_reg[k-1];
            end
        end
    end

    // Stages 2 and 3: squared and cross products.
    logic [LW-1:0] pdd [3];
    logic [LW-1:0] pqq [3];
    logic [LW-1:0] pdq [3];
    logic [2*(RW+1)-1:0] rs;

    for (genvar g = 0; g < 3; g++)
    begin : g_sq
        ssot_mul #(.AW(DW), .BW(DW)) u_dd
            (.clk(clk), .en(en), .a(md_reg[g]), .b(md_reg[g]), .p(pdd[g]));
        ssot_mul #(.AW(DW), .BW(DW)) u_qq
            (.clk(clk), .en(en), .a(mq_reg[g]), .b(mq_reg[g]), .p(pqq[g]));
        ssot_mul #(.AW(DW), .BW(DW)) u_dq
            (.clk(clk), .en(en), .a(md_reg[g]), .b(mq_reg[g]), .p(pdq[g]));
    end

    ssot_mul #(.AW(RW+1), .BW(RW+1)) u_rs
        (.clk(clk), .en(en), .a(rsum_reg), .b(rsum_reg), .p(rs));

    // Stage 4: length, distance and projection with range checks.
    logic [LW-1:0] len_c, qq_c, pos_c, neg_c, dot_c;
    logic [LW-1:0] len_reg [4];
    logic [LW-1:0] qq_reg, dot_reg, lmd_reg;
    logic [RW-1:0] r0_4_reg, r1_4_reg, rq_4_reg;
    side_t side_reg [6];

    always_comb
    begin
        len_c = '0;
        qq_c  = '0;
        pos_c = '0;
        neg_c = '0;
        for (int i = 0; i < 3; i++)
        begin
            len_c = len_c + pdd[i];
            qq_c  = qq_c + pqq[i];
            if (sgn_reg[2][i])
            begin
                neg_c = neg_c + pdq[i];
            end
            else
            begin
                pos_c = pos_c + pdq[i];
            end
        end
        dot_c = pos_c - neg_c;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            len_reg[0] <= len_c;
            qq_reg     <= qq_c;
            dot_reg    <= dot_c;
            lmd_reg    <= len_c - dot_c;
            r0_4_reg   <= r0_reg[2];
            r1_4_reg   <= r1_reg[2];
            rq_4_reg   <= rq_reg[2];
            side_reg[0].still   <= still_reg[2];
            side_reg[0].near    <= qq_c < LW'(rs);
            side_reg[0].outside <= (pos_c < neg_c) || (dot_c > len_c);
            for (int k = 1; k < 4; k++)
            begin
                len_reg[k] <= len_reg[k-1];
            end
            for (int k = 1; k < 6; k++)
            begin
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    // Stages 5 and 6: products of the first order.
    logic [QLW-1:0]   qql, d2;
    logic [RW+LW-1:0] rql, r0b, r1d;

    ssot_mul #(.AW(LW), .BW(LW)) u_qql
        (.clk(clk), .en(en), .a(qq_reg), .b(len_reg[0]), .p(qql));
    ssot_mul #(.AW(LW), .BW(LW)) u_d2
        (.clk(clk), .en(en), .a(dot_reg), .b(dot_reg), .p(d2));
    ssot_mul #(.AW(RW), .BW(LW)) u_rql
        (.clk(clk), .en(en), .a(rq_4_reg), .b(len_reg[0]), .p(rql));
    ssot_mul #(.AW(RW), .BW(LW)) u_r0b
        (.clk(clk), .en(en), .a(r0_4_reg), .b(lmd_reg), .p(r0b));
    ssot_mul #(.AW(RW), .BW(LW)) u_r1d
        (.clk(clk), .en(en), .a(r1_4_reg), .b(dot_reg), .p(r1d));

    // Stage 7: perpendicular distance term and interpolated radius sum.
    logic [QLW-1:0] lhs1_reg;
    logic [RLW-1:0] rlin_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lhs1_reg <= qql - d2;
            rlin_reg <= RLW'(rql) + RLW'(r0b) + RLW'(r1d);
        end
    end

    // Stages 8 and 9: final products.
    logic [FW-1:0]    lhs;
    logic [2*RLW-1:0] rl;

    ssot_mul #(.AW(QLW), .BW(LW)) u_lhs
        (.clk(clk), .en(en), .a(lhs1_reg), .b(len_reg[3]), .p(lhs));
    ssot_mul #(.AW(RLW), .BW(RLW)) u_rl
        (.clk(clk), .en(en), .a(rlin_reg), .b(rlin_reg), .p(rl));

    // Stage 10: decision and output register.
    logic hit_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (side_reg[5].still)
            begin
                hit_reg <= side_reg[5].near;
            end
            else if (side_reg[5].outside)
            begin
                hit_reg <= 1'b0;
            end
            else
            begin
                hit_reg <= FW'(lhs) < FW'(rl);
            end
        end
    end

    assign hit = hit_reg;

endmodule
`default_nettype wire
